// ===== rtl/rgbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbh_pkg: shared types and constants for the RGB to HSV converter
// Channel width, hue scale, divider sizing and the item structs used on the
// converter ports and between its pipeline parts.
// ----------------------------------------------------------------------------
package rgbh_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int HUE_BITS = 15;

  // Hue is in 1/64 degree: one sixth of the circle is 60 * 64.
  localparam int HUE_SIXTH_BITS = 12;
  localparam logic [HUE_BITS-1:0] HUE_SIXTH = 15'd3840;
  localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE = 15'd15360;
  localparam logic [HUE_BITS-1:0] HUE_FULL = 15'd23040;

  // One quotient bit per divider stage. The quotient must hold both the
  // saturation (a full channel) and a hue offset of up to one sixth.
  localparam int DIV_Q_BITS = (CHANNEL_BITS > HUE_SIXTH_BITS) ? CHANNEL_BITS
                                                              : HUE_SIXTH_BITS;
  localparam int NUM_BITS = CHANNEL_BITS + DIV_Q_BITS;

  // Clock edges from an accepted item to the sampled result strobe.
  localparam int PIPE_LATENCY = DIV_Q_BITS + 3;

  localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = {CHANNEL_BITS{1'b1}};
  localparam logic [CHANNEL_BITS-1:0] DARK_RESET = CHANNEL_BITS'(1);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    gray;
  } hsv_t;

  // Per-item information that rides alongside the dividers.
  typedef struct packed {
    logic                    dark;
    logic                    neg;
    sector_t                 sector;
    logic [CHANNEL_BITS-1:0] vmax;
  } side_t;

endpackage

// ===== rtl/rgbh_front.sv =====
// ----------------------------------------------------------------------------
// rgbh_front: channel sort and divider operand setup
// Stage one finds max, min, sector, delta, the dark flag and the signed channel
// difference. Stage two forms the saturation and hue dividends.
// ----------------------------------------------------------------------------
module rgbh_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  rgbh_pkg::pixel_t                in_pixel,
  input  logic [rgbh_pkg::CHANNEL_BITS-1:0] thr,
  output logic                            out_vld,
  output rgbh_pkg::side_t                 out_side,
  output logic [rgbh_pkg::NUM_BITS-1:0]     sat_num,
  output logic [rgbh_pkg::CHANNEL_BITS-1:0] sat_den,
  output logic [rgbh_pkg::NUM_BITS-1:0]     hue_num,
  output logic [rgbh_pkg::CHANNEL_BITS-1:0] hue_den
);
  import rgbh_pkg::*;

  logic [CHANNEL_BITS-1:0] r, g, b;
  logic [CHANNEL_BITS-1:0] mx, mn, op_a, op_b;
  sector_t                 sector;

  logic                    s1_vld_r;
  logic [CHANNEL_BITS-1:0] s1_mx_r, s1_delta_r, s1_diff_r;
  logic                    s1_neg_r, s1_dark_r;
  sector_t                 s1_sector_r;

  logic                    s2_vld_r;
  side_t                   s2_side_r;
  logic [NUM_BITS-1:0]     s2_sat_num_r, s2_hue_num_r;
  logic [CHANNEL_BITS-1:0] s2_sat_den_r, s2_hue_den_r;

  assign r = in_pixel.red;
  assign g = in_pixel.green;
  assign b = in_pixel.blue;

  // Ties favor red, then green.
  always_comb begin
    if (r >= g && r >= b) begin
      sector = SEC_RED;
      mx     = r;
      op_a   = g;
      op_b   = b;
    end else if (g >= b) begin
      sector = SEC_GREEN;
      mx     = g;
      op_a   = b;
      op_b   = r;
    end else begin
      sector = SEC_BLUE;
      mx     = b;
      op_a   = r;
      op_b   = g;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r     <= mx;
    s1_delta_r  <= mx - mn;
    s1_neg_r    <= (op_a < op_b);
    s1_diff_r   <= (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    s1_sector_r <= sector;
    s1_dark_r   <= (mx < thr) || (mx == '0);
  end

  // Saturation dividend is delta * full scale, done as a shift and subtract.
  always_ff @(posedge clk) begin
    s2_side_r.dark   <= s1_dark_r;
    s2_side_r.neg    <= s1_neg_r;
    s2_side_r.sector <= s1_sector_r;
    s2_side_r.vmax   <= s1_mx_r;
    s2_sat_num_r     <= (NUM_BITS'(s1_delta_r) << CHANNEL_BITS) - NUM_BITS'(s1_delta_r);
    s2_sat_den_r     <= s1_mx_r;
    s2_hue_num_r     <= NUM_BITS'(s1_diff_r) * NUM_BITS'(HUE_SIXTH);
    s2_hue_den_r     <= s1_delta_r;
  end

  assign out_vld  = s2_vld_r;
  assign out_side = s2_side_r;
  assign sat_num  = s2_sat_num_r;
  assign sat_den  = s2_sat_den_r;
  assign hue_num  = s2_hue_num_r;
  assign hue_den  = s2_hue_den_r;

endmodule

// ===== rtl/rgbh_div.sv =====
// ----------------------------------------------------------------------------
// rgbh_div: pipelined restoring divider
// One quotient bit per stage. The dividend must be below divisor times two to
// the quotient width, true of both converter uses while the divisor is nonzero.
// ----------------------------------------------------------------------------
module rgbh_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [rgbh_pkg::NUM_BITS-1:0]     in_num,
  input  logic [rgbh_pkg::CHANNEL_BITS-1:0] in_den,
  output logic                              out_vld,
  output logic [rgbh_pkg::DIV_Q_BITS-1:0]   out_quo
);
  import rgbh_pkg::*;

  localparam int STAGES = DIV_Q_BITS;

  logic                    vld_r [STAGES];
  logic [CHANNEL_BITS-1:0] rem_r [STAGES];
  logic [DIV_Q_BITS-1:0]   low_r [STAGES];
  logic [DIV_Q_BITS-1:0]   quo_r [STAGES];
  logic [CHANNEL_BITS-1:0] den_r [STAGES];

  logic                    vld_nxt [STAGES];
  logic [CHANNEL_BITS-1:0] rem_nxt [STAGES];
  logic [DIV_Q_BITS-1:0]   low_nxt [STAGES];
  logic [DIV_Q_BITS-1:0]   quo_nxt [STAGES];
  logic [CHANNEL_BITS-1:0] den_nxt [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                    p_vld;
    logic [CHANNEL_BITS-1:0] p_rem, p_den;
    logic [DIV_Q_BITS-1:0]   p_low, p_quo;
    logic [CHANNEL_BITS:0]   trial;
    logic                    ge;

    if (s == 0) begin : g_first
      // The upper dividend bits are already below the divisor.
      assign p_vld = in_vld;
      assign p_rem = in_num[NUM_BITS-1:DIV_Q_BITS];
      assign p_low = in_num[DIV_Q_BITS-1:0];
      assign p_quo = '0;
      assign p_den = in_den;
    end else begin : g_next
      assign p_vld = vld_r[s-1];
      assign p_rem = rem_r[s-1];
      assign p_low = low_r[s-1];
      assign p_quo = quo_r[s-1];
      assign p_den = den_r[s-1];
    end

    always_comb begin
      trial      = {p_rem, p_low[DIV_Q_BITS-1]};
      ge         = (trial >= {1'b0, p_den});
      vld_nxt[s] = p_vld;
      rem_nxt[s] = ge ? CHANNEL_BITS'(trial - {1'b0, p_den}) : trial[CHANNEL_BITS-1:0];
      low_nxt[s] = p_low << 1;
      quo_nxt[s] = {p_quo[DIV_Q_BITS-2:0], ge};
      den_nxt[s] = p_den;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      quo_r[s] <= quo_nxt[s];
      den_r[s] <= den_nxt[s];
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_quo = quo_r[STAGES-1];

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: pipelined RGB to HSV pixel converter
// Converts one pixel per clock into hue, saturation, value and a gray flag.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_pixel) is taken at each rising edge where start is high and
//   busy is low. busy is always low, so a pixel may be offered every cycle.
//   Each result shows on out_hsv for one cycle with out_strobe high; the
//   receiver cannot hold results off and the block never needs it to.
//   The item passes two setup stages, one stage per quotient bit of the
//   16-stage dividers and the output register before the strobe rises.
//   Throughput is one item per cycle, set by the fully pipelined saturation
//   and hue dividers running side by side.
//   The dark threshold is written through cfg_valid/cfg_data; cfg_ready is
//   always high. Write it only while no items are in flight.
//   Reset (rst_n low, synchronous) drops all items in flight and sets the
//   dark threshold to one.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rgbh_pkg::pixel_t                  in_pixel,
  output logic                              out_strobe,
  output rgbh_pkg::hsv_t                    out_hsv,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbh_pkg::CHANNEL_BITS-1:0] cfg_data
);
  import rgbh_pkg::*;

  logic [CHANNEL_BITS-1:0] thr_r;

  logic                    fr_vld;
  side_t                   fr_side;
  logic [NUM_BITS-1:0]     sat_num, hue_num;
  logic [CHANNEL_BITS-1:0] sat_den, hue_den;

  logic                    sat_vld, hue_vld;
  logic [DIV_Q_BITS-1:0]   sat_quo, hue_quo;

  side_t                   side_r [DIV_Q_BITS];

  logic [CHANNEL_BITS-1:0] sat;
  logic [HUE_BITS-1:0]     q;
  logic [HUE_BITS-1:0]     hue;
  side_t                   sd;

  logic                    out_strobe_r;
  hsv_t                    out_hsv_r, out_hsv_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= DARK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  rgbh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_pixel (in_pixel),
    .thr      (thr_r),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .sat_num  (sat_num),
    .sat_den  (sat_den),
    .hue_num  (hue_num),
    .hue_den  (hue_den)
  );

  rgbh_div u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_num  (sat_num),
    .in_den  (sat_den),
    .out_vld (sat_vld),
    .out_quo (sat_quo)
  );

  rgbh_div u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_num  (hue_num),
    .in_den  (hue_den),
    .out_vld (hue_vld),
    .out_quo (hue_quo)
  );

  // Sideband delay line matching the divider depth.
  always_ff @(posedge clk) begin
    side_r[0] <= fr_side;
    for (int i = 1; i < DIV_Q_BITS; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  always_comb begin
    sd  = side_r[DIV_Q_BITS-1];
    sat = CHANNEL_BITS'(sat_quo);
    q   = HUE_BITS'(hue_quo);
    case (sd.sector)
      SEC_RED: begin
        // A negative offset wraps around the full circle.
        hue = (sd.neg && q != '0) ? (HUE_FULL - q) : q;
      end
      SEC_GREEN: begin
        hue = sd.neg ? (HUE_GREEN_BASE - q) : (HUE_GREEN_BASE + q);
      end
      SEC_BLUE: begin
        hue = sd.neg ? (HUE_BLUE_BASE - q) : (HUE_BLUE_BASE + q);
      end
      default: begin
        hue = '0;
      end
    endcase

    if (sd.dark) begin
      out_hsv_nxt.hue        = '0;
      out_hsv_nxt.saturation = '0;
      out_hsv_nxt.brightness = '0;
      out_hsv_nxt.gray       = 1'b1;
    end else if (sat == '0) begin
      out_hsv_nxt.hue        = '0;
      out_hsv_nxt.saturation = '0;
      out_hsv_nxt.brightness = sd.vmax;
      out_hsv_nxt.gray       = 1'b1;
    end else begin
      out_hsv_nxt.hue        = hue;
      out_hsv_nxt.saturation = sat;
      out_hsv_nxt.brightness = sd.vmax;
      out_hsv_nxt.gray       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= sat_vld && hue_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hsv_r <= out_hsv_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_hsv    = out_hsv_r;

  // Every result comes from an item accepted a fixed number of edges earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_LATENCY))
    else $error("result strobe without a matching accepted item");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hsv.gray) |-> (out_hsv.hue < HUE_FULL))
    else $error("hue out of range");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hsv.gray) |-> (out_hsv.hue == '0 && out_hsv.saturation == '0))
    else $error("gray result with nonzero hue or saturation");

  a_color_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hsv.gray) |-> (out_hsv.saturation != '0 && out_hsv.brightness != '0))
    else $error("colored result with zero saturation or brightness");

endmodule
